>>> hw/rtl/sprd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprd_pkg
// Types and constants for the sensor reply frame deframer.
// ----------------------------------------------------------------------------
package sprd_pkg;

    // Frame header bytes
    localparam logic [7:0] HDR_FIRST  = 8'hEF;
    localparam logic [7:0] HDR_SECOND = 8'h01;

    // Result status codes
    localparam logic [1:0] STATUS_GOOD    = 2'd0;
    localparam logic [1:0] STATUS_CSUM    = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

    // Stream widths
    localparam int unsigned RX_TDATA_W  = 8;
    localparam int unsigned RES_TDATA_W = 32;
    localparam int unsigned RES_TUSER_W = 3;

    // One result beat
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] package_id;
        logic [7:0] confirm_code;
        logic       param_valid;
        logic [4:0] param_index;
        logic [7:0] param_byte;
        logic       last;
    } result_t;

endpackage

>>> hw/rtl/sensor_reply_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_reply_packet_deframer
// Receives reply frames byte by byte, checks header, address, length and
// additive checksum, and streams out a good frame's params or a status beat.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one received byte per beat (s_tdata[7:0]).
//   cfg_* channel: writes the 32-bit module address; cfg_ready is always high.
//     Write it only while no frame is in progress.
//   m_* channel: result beats. tuser = {param_valid, status}, tlast marks the
//     final beat of a frame.
// Timing:
//   A single result (bad length, checksum mismatch, good frame without
//   parameters) is loaded into the output register at the edge that takes
//   the byte. A good frame with N parameter bytes loads its first beat in
//   the cycle after its last byte, once entry zero has been read out into
//   the read register, then one beat per cycle while the receiver takes
//   them; no byte is accepted until the last of them is loaded.
//   s_tready also drops while a result waits in the output register and the
//   receiver holds m_tready low; the block simply holds until it is taken.
// Reset:
//   rst_n clears the frame position and the output valid and loads the
//   address register with all ones. The parameter memory is not cleared.
// ----------------------------------------------------------------------------
module sensor_reply_packet_deframer
    import sprd_pkg::*;
#(
    parameter int unsigned MAX_PARAMS = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // cfg_data: module_address[31:0]
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [31:0]             cfg_data,
    // s_tdata: rx_byte[7:0]
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [RX_TDATA_W-1:0]   s_tdata,
    // m_tdata: package_id[7:0], confirm_code[15:8], param_index[20:16],
    //          param_byte[28:21], zero[31:29]
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [RES_TDATA_W-1:0]  m_tdata,
    // m_tuser: status[1:0], param_valid[2]
    output logic [RES_TUSER_W-1:0]  m_tuser,
    output logic                    m_tlast
);

    localparam int unsigned AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int unsigned CW = $clog2(MAX_PARAMS + 1);
    localparam int unsigned PW = $clog2(MAX_PARAMS + 13);

    typedef enum logic {
        ST_RX,
        ST_EMIT
    } state_t;

    // Registers
    state_t          state_reg, state_next;
    logic [31:0]     addr_reg, addr_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [15:0]     len_reg, len_next;
    logic [15:0]     sum_reg, sum_next;
    logic [7:0]      pid_reg, pid_next;
    logic [7:0]      conf_reg, conf_next;
    logic [7:0]      chk_hi_reg, chk_hi_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [CW-1:0]   nparams_reg, nparams_next;
    logic            out_valid_reg, out_valid_next;
    result_t         out_reg, out_next;

    // Parameter memory
    logic [7:0]      param_mem [MAX_PARAMS];
    logic [7:0]      rd_data_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [7:0]      mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;

    // Byte decode helpers
    logic            out_free;
    logic            rx_fire;
    logic [7:0]      rx_b;
    logic [PW-1:0]   p;
    logic [PW-1:0]   idx;
    logic [15:0]     len_w;
    logic [7:0]      want;
    logic [15:0]     got;
    logic            emit_last;

    assign out_free  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_RX) && out_free;
    assign rx_fire   = s_tvalid && s_tready;
    assign rx_b      = s_tdata[7:0];
    assign p         = pos_reg + PW'(1);
    assign idx       = p - PW'(11);
    assign len_w     = {len_reg[15:8], rx_b};
    assign got       = {chk_hi_reg, rx_b};
    assign emit_last = (({1'b0, k_reg} + (CW+1)'(1)) == {1'b0, nparams_reg});

    // Pick the expected address byte, most significant first
    always_comb
    begin
        case (p[2:0])
            3'd3:    want = addr_reg[31:24];
            3'd4:    want = addr_reg[23:16];
            3'd5:    want = addr_reg[15:8];
            default: want = addr_reg[7:0];
        endcase
    end

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        sum_next       = sum_reg;
        pid_next       = pid_reg;
        conf_next      = conf_reg;
        chk_hi_next    = chk_hi_reg;
        k_next         = k_reg;
        nparams_next   = nparams_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx[AW-1:0];
        mem_wdata      = rx_b;
        mem_re         = 1'b0;
        mem_raddr      = AW'(k_reg + CW'(1));

        // Retire the current output beat
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        // Take a configuration write
        if (cfg_valid)
        begin
            addr_next = cfg_data;
        end

        case (state_reg)
            ST_RX:
            begin
                if (rx_fire)
                begin
                    pos_next = p;
                    if (p == PW'(1))
                    begin
                        if (rx_b != HDR_FIRST)
                        begin
                            pos_next = '0;
                        end
                    end
                    else if (p == PW'(2))
                    begin
                        if (rx_b != HDR_SECOND)
                        begin
                            pos_next = '0;
                        end
                    end
                    else if (p <= PW'(6))
                    begin
                        if (rx_b != want)
                        begin
                            pos_next = '0;
                        end
                    end
                    else if (p == PW'(7))
                    begin
                        pid_next = rx_b;
                        sum_next = {8'h00, rx_b};
                    end
                    else if (p == PW'(8))
                    begin
                        len_next = {rx_b, 8'h00};
                        sum_next = sum_reg + {8'h00, rx_b};
                    end
                    else if (p == PW'(9))
                    begin
                        len_next = len_w;
                        sum_next = sum_reg + {8'h00, rx_b};
                        // Drop frames whose length is out of range
                        if ((len_w < 16'd3) ||
                            ({1'b0, len_w} > 17'(MAX_PARAMS + 3)))
                        begin
                            pos_next                = '0;
                            out_valid_next          = 1'b1;
                            out_next                = '0;
                            out_next.status         = STATUS_BAD_LEN;
                            out_next.package_id     = pid_reg;
                            out_next.last           = 1'b1;
                        end
                    end
                    else if (p == PW'(10))
                    begin
                        conf_next = rx_b;
                        sum_next  = sum_reg + {8'h00, rx_b};
                    end
                    else if (17'(p) <= ({1'b0, len_reg} + 17'd7))
                    begin
                        // Store a parameter byte
                        if (idx < PW'(MAX_PARAMS))
                        begin
                            mem_we = 1'b1;
                        end
                        sum_next = sum_reg + {8'h00, rx_b};
                    end
                    else if (17'(p) == ({1'b0, len_reg} + 17'd8))
                    begin
                        chk_hi_next = rx_b;
                    end
                    else
                    begin
                        // Frame end: check the sum and report
                        pos_next            = '0;
                        out_next            = '0;
                        out_next.package_id = pid_reg;
                        out_next.confirm_code = conf_reg;
                        out_next.last       = 1'b1;
                        if (got != sum_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_next.status = STATUS_CSUM;
                        end
                        else if (len_reg == 16'd3)
                        begin
                            out_valid_next  = 1'b1;
                            out_next.status = STATUS_GOOD;
                        end
                        else
                        begin
                            // Start the parameter burst: fetch entry zero
                            state_next   = ST_EMIT;
                            k_next       = '0;
                            nparams_next = CW'(len_reg - 16'd3);
                            mem_re       = 1'b1;
                            mem_raddr    = '0;
                        end
                    end
                end
            end

            ST_EMIT:
            begin
                // Load one parameter beat and fetch the next entry
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.status       = STATUS_GOOD;
                    out_next.package_id   = pid_reg;
                    out_next.confirm_code = conf_reg;
                    out_next.param_valid  = 1'b1;
                    out_next.param_index  = 5'(k_reg);
                    out_next.param_byte   = rd_data_reg;
                    out_next.last         = emit_last;
                    if (emit_last)
                    begin
                        state_next = ST_RX;
                    end
                    else
                    begin
                        k_next = k_reg + CW'(1);
                        mem_re = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_RX;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RX;
            addr_reg      <= 32'hFFFF_FFFF;
            pos_reg       <= '0;
            len_reg       <= '0;
            sum_reg       <= '0;
            pid_reg       <= '0;
            conf_reg      <= '0;
            chk_hi_reg    <= '0;
            k_reg         <= '0;
            nparams_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            sum_reg       <= sum_next;
            pid_reg       <= pid_next;
            conf_reg      <= conf_next;
            chk_hi_reg    <= chk_hi_next;
            k_reg         <= k_next;
            nparams_reg   <= nparams_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    // Parameter memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            param_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= param_mem[mem_raddr];
        end
    end

    // Drive the result channel
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.param_byte, out_reg.param_index,
                       out_reg.confirm_code, out_reg.package_id};
    assign m_tuser  = {out_reg.param_valid, out_reg.status};
    assign m_tlast  = out_reg.last;

endmodule

>>> tb/sensor_reply_packet_deframer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_reply_packet_deframer_test
// Streams reply frames into the deframer byte by byte and checks every
// result beat against a frame tracker kept inside the bench. Covers header,
// address, length and checksum faults, empty and full parameter lists, and
// several module addresses. Sender bursts and receiver stalls vary
// throughout, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module sensor_reply_packet_deframer_test
    import sprd_pkg::*;
();

    localparam int MAX_PARAMS  = 32;
    localparam int SETTLE      = 2 * MAX_PARAMS + 8;
    localparam int LONG_HOLD   = 600;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_SHOWN   = 10;
    localparam int PHASE_BYTES = 64;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CADENCE} rx_mode_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // Bench copy of the address register and of the frame tracker
    logic [31:0] mod_addr = 32'hFFFF_FFFF;
    int unsigned fr_pos   = 0;
    logic [15:0] fr_len   = '0;
    logic [15:0] fr_sum   = '0;
    logic [7:0]  fr_pid   = '0;
    logic [7:0]  fr_conf  = '0;
    logic [7:0]  fr_csum_hi = '0;
    logic [7:0]  fr_params [MAX_PARAMS];

    logic [7:0]  pend_q [$];
    result_t     reply_q [$];
    int unsigned bytes_queued = 0;
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;
    logic        hold_arm     = 1'b0;

    sensor_reply_packet_deframer #(
        .MAX_PARAMS (MAX_PARAMS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Track one received byte and queue the replies it releases
    task automatic deframe_byte(input logic [7:0] b);
        int unsigned p;
        int unsigned n;
        int unsigned k;
        logic [15:0] got;
        result_t     r;
        p      = fr_pos + 1;
        fr_pos = p;
        r      = '0;
        if (p == 1) begin
            if (b != HDR_FIRST) fr_pos = 0;
        end
        else if (p == 2) begin
            if (b != HDR_SECOND) fr_pos = 0;
        end
        else if (p <= 6) begin
            if (b != mod_addr[8 * (6 - p) +: 8]) fr_pos = 0;
        end
        else if (p == 7) begin
            fr_pid = b;
            fr_sum = {8'h00, b};
        end
        else if (p == 8) begin
            fr_len = {b, 8'h00};
            fr_sum = fr_sum + b;
        end
        else if (p == 9) begin
            fr_len[7:0] = b;
            fr_sum      = fr_sum + b;
            if (fr_len < 3 || int'(fr_len) - 3 > MAX_PARAMS) begin
                r.status     = STATUS_BAD_LEN;
                r.package_id = fr_pid;
                r.last       = 1'b1;
                reply_q.push_back(r);
                fr_pos = 0;
            end
        end
        else if (p == 10) begin
            fr_conf = b;
            fr_sum  = fr_sum + b;
        end
        else if (p <= 7 + int'(fr_len)) begin
            fr_params[p - 11] = b;
            fr_sum = fr_sum + b;
        end
        else if (p == 8 + int'(fr_len)) begin
            fr_csum_hi = b;
        end
        else begin
            // Frame end: second checksum byte
            fr_pos = 0;
            got    = {fr_csum_hi, b};
            n      = int'(fr_len) - 3;
            r.package_id   = fr_pid;
            r.confirm_code = fr_conf;
            if (got != fr_sum || n == 0) begin
                r.status = (got != fr_sum) ? STATUS_CSUM : STATUS_GOOD;
                r.last   = 1'b1;
                reply_q.push_back(r);
            end
            else begin
                for (k = 0; k < n; k++) begin
                    r.status      = STATUS_GOOD;
                    r.param_valid = 1'b1;
                    r.param_index = k[4:0];
                    r.param_byte  = fr_params[k];
                    r.last        = (k + 1 == n);
                    reply_q.push_back(r);
                end
            end
        end
    endtask

    // Sender: bursts of random length with random gaps in between
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(posedge clk)
    begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end
        else begin
            if (s_tvalid && s_tready) deframe_byte(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pend_q.size() > 0) begin
                    s_tdata  <= pend_q.pop_front();
                    s_tvalid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end
                    else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0
                                   : $urandom_range(1, 8);
                    end
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern of its own, plus one long hold-off when armed
    rx_mode_t    rx_mode     = RX_OPEN;
    int unsigned mode_left   = 0;
    int unsigned cadence_len = 3;
    int unsigned cadence_cnt = 0;
    int unsigned hold_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else if (hold_arm && hold_cycles < LONG_HOLD) begin
            hold_cycles++;
            m_tready <= 1'b0;
        end
        else begin
            if (mode_left == 0) begin
                rx_mode     = rx_mode_t'($urandom_range(0, 2));
                mode_left   = $urandom_range(16, 160);
                cadence_len = $urandom_range(2, 5);
            end
            mode_left--;
            case (rx_mode)
                RX_OPEN:  m_tready <= 1'b1;
                RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
                default:
                begin
                    m_tready    <= (cadence_cnt == 0);
                    cadence_cnt  = (cadence_cnt + 1) % cadence_len;
                end
            endcase
        end
    end

    function automatic string beat_text(input result_t r);
        return $sformatf("st=%0d pid=%02h cc=%02h pv=%0d idx=%0d pb=%02h last=%0d",
                         r.status, r.package_id, r.confirm_code, r.param_valid,
                         r.param_index, r.param_byte, r.last);
    endfunction

    task automatic note_mismatch(input string why, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("%s: expected %s, got %s", why, beat_text(want), beat_text(got));
    endtask

    // Monitor: compare each result beat with the oldest expected reply
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got.status       = m_tuser[1:0];
            got.param_valid  = m_tuser[2];
            got.package_id   = m_tdata[7:0];
            got.confirm_code = m_tdata[15:8];
            got.param_index  = m_tdata[20:16];
            got.param_byte   = m_tdata[28:21];
            got.last         = m_tlast;
            if (reply_q.size() == 0) begin
                note_mismatch("unexpected beat", '0, got);
            end
            else begin
                want = reply_q.pop_front();
                if (got !== want) note_mismatch("wrong beat", want, got);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [7:0] header_byte(input int unsigned i);
        case (i)
            0:       return HDR_FIRST;
            1:       return HDR_SECOND;
            default: return mod_addr[8 * (5 - i) +: 8];
        endcase
    endfunction

    task automatic put_byte(input logic [7:0] b);
        pend_q.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_header(input int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++) put_byte(header_byte(i));
    endtask

    // Queue a complete frame; a bad length stops after the length bytes
    task automatic push_frame(input logic [7:0] pid, input logic [15:0] len,
                              input logic [7:0] conf, input bit corrupt);
        logic [15:0] sum;
        logic [7:0]  pb;
        int          i;
        push_header(6);
        put_byte(pid);
        put_byte(len[15:8]);
        put_byte(len[7:0]);
        sum = pid + len[15:8] + len[7:0];
        if (len >= 3 && int'(len) - 3 <= MAX_PARAMS) begin
            put_byte(conf);
            sum = sum + conf;
            for (i = 0; i < int'(len) - 3; i++) begin
                pb  = 8'($urandom_range(0, 255));
                sum = sum + pb;
                put_byte(pb);
            end
            if (corrupt) sum = sum ^ 16'($urandom_range(1, 65535));
            put_byte(sum[15:8]);
            put_byte(sum[7:0]);
        end
    endtask

    // Queue a header cut short by one wrong byte
    task automatic push_broken();
        int unsigned n;
        logic [7:0]  w;
        n = $urandom_range(0, 5);
        push_header(n);
        if (header_byte(n) != HDR_FIRST && $urandom_range(0, 3) == 0) begin
            w = HDR_FIRST;
        end
        else begin
            do w = 8'($urandom_range(0, 255)); while (w == header_byte(n));
        end
        put_byte(w);
    endtask

    task automatic random_traffic(input int unsigned n_bytes);
        int unsigned start;
        int unsigned pick;
        logic [15:0] len;
        start = bytes_queued;
        while (bytes_queued - start < n_bytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                push_broken();
            end
            else if (pick < 14) begin
                put_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 22) begin
                do len = 16'($urandom_range(0, 65535));
                while (len >= 3 && len <= 3 + MAX_PARAMS);
                if ($urandom_range(0, 1) == 1)
                    len = 16'($urandom_range(0, 2) + 4 + MAX_PARAMS * $urandom_range(0, 1)
                              - 4 * $urandom_range(0, 1));
                if (len >= 3 && len <= 3 + MAX_PARAMS) len = 16'd36;
                push_frame(8'($urandom_range(0, 255)), len, 8'($urandom_range(0, 255)),
                           1'b0);
            end
            else begin
                pick = $urandom_range(0, 9);
                len  = (pick == 0) ? 16'(3 + MAX_PARAMS) : (pick == 1) ? 16'd3
                     : 16'($urandom_range(4, 14));
                push_frame(8'($urandom_range(0, 255)), len, 8'($urandom_range(0, 255)),
                           $urandom_range(0, 7) == 0);
            end
        end
    endtask

    // Hold the sender until every reply is in and the tracker sits between
    // frames; pad a half-finished frame with zero bytes
    task automatic wait_idle();
        bit busy;
        busy = 1'b1;
        while (busy) begin
            while (pend_q.size() != 0 || s_tvalid || reply_q.size() != 0) @(posedge clk);
            repeat (SETTLE) @(posedge clk);
            @(negedge clk);
            busy = (fr_pos != 0) || (pend_q.size() != 0) || s_tvalid
                || (reply_q.size() != 0);
            if (fr_pos != 0 && pend_q.size() == 0 && !s_tvalid && reply_q.size() == 0)
                put_byte(8'h00);
        end
    endtask

    task automatic write_address(input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mod_addr   = value;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: noise, broken header, broken address, length extremes,
        // smallest good frame and a checksum fault, all under the reset address
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(HDR_FIRST);
        put_byte(8'h00);
        push_header(4);
        put_byte(8'h7F);
        push_frame(8'h00, 16'h0000, 8'h00, 1'b0);
        push_frame(8'hFF, 16'hFFFF, 8'h00, 1'b0);
        push_frame(8'hA5, 16'h0003, 8'h5A, 1'b0);
        push_frame(8'h3C, 16'h0003, 8'hFF, 1'b1);
        wait_idle();
        random_traffic(PHASE_BYTES);
        wait_idle();

        write_address(32'h0000_0000);
        random_traffic(PHASE_BYTES);
        wait_idle();

        // Long receiver hold-off behind a full parameter list
        write_address($urandom);
        hold_arm = 1'b1;
        push_frame(8'($urandom_range(0, 255)), 16'(3 + MAX_PARAMS),
                   8'($urandom_range(0, 255)), 1'b0);
        random_traffic(PHASE_BYTES);
        wait_idle();

        write_address({HDR_FIRST, HDR_SECOND, HDR_FIRST, HDR_SECOND});
        random_traffic(PHASE_BYTES / 2);
        wait_idle();
        random_traffic(PHASE_BYTES / 2);
        wait_idle();

        write_address(32'hFFFF_FFFF);
        random_traffic(PHASE_BYTES);
        wait_idle();

        if (mismatches == 0 && reply_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
